// ===== src/i2c_master_byte_engine_macros.svh =====
// Assertion macros for the I2C master byte engine.
// Used by the top level; expects aclk and aresetn in scope at the point of use.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define I2CMBE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("i2cmbe check failed");
`define I2CMBE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cmbe check failed");
`else
`define I2CMBE_ASSERT(lbl, cond)
`define I2CMBE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/i2cmbe_pkg.sv =====
// Shared types, command codes and phase counts for the I2C master byte engine.
// No dependencies.
package i2cmbe_pkg;

    localparam int MODE_W    = 3;
    localparam int PHASE_W   = 5;
    localparam int SUB_W     = 2;
    localparam int DELAY_W   = 16;
    localparam int BYTE_W    = 8;

    localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_ACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RD_NACK = 3'd4;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

    // Write phase landmarks
    localparam logic [PHASE_W-1:0] PH_WR_LAST_BIT = 5'd23;
    localparam logic [PHASE_W-1:0] PH_WR_ACK_REL  = 5'd24;
    localparam logic [PHASE_W-1:0] PH_WR_ACK_HIGH = 5'd25;
    // Read phase landmarks
    localparam logic [PHASE_W-1:0] PH_RD_ACK_DRV  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RD_ACK_HIGH = 5'd17;

    // Sub-phase within one write bit
    localparam logic [SUB_W-1:0] SUB_DATA = 2'd0;
    localparam logic [SUB_W-1:0] SUB_HIGH = 2'd1;
    localparam logic [SUB_W-1:0] SUB_LOW  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;
        logic [SUB_W-1:0]   sub;
        logic [DELAY_W-1:0] div;
        logic [BYTE_W-1:0]  shreg;
        logic               busy;
        logic               scl;
        logic               sda;
        logic               ack;
        logic [BYTE_W-1:0]  rd_latch;
    } engine_state_t;

    // Number of bus phases for each command
    function automatic logic [PHASE_W-1:0] phase_count(input logic [MODE_W-1:0] m);
        logic [PHASE_W-1:0] n;
        case (m)
            MODE_START: n = 5'd3;
            MODE_STOP:  n = 5'd1;
            MODE_WRITE: n = 5'd27;
            default:    n = 5'd19;
        endcase
        return n;
    endfunction

    function automatic logic is_read(input logic [MODE_W-1:0] m);
        return (m == MODE_RD_ACK) || (m == MODE_RD_NACK);
    endfunction

endpackage

// ===== src/i2cmbe_step.sv =====
// One-tick next-state logic of the I2C master byte engine.
// Depends on i2cmbe_pkg.
module i2cmbe_step
    import i2cmbe_pkg::*;
(
    input  engine_state_t      st,
    input  logic [DELAY_W-1:0] delay_ticks,
    input  logic               cmd_valid,
    input  logic [MODE_W-1:0]  mode,
    input  logic [BYTE_W-1:0]  wr_byte,
    input  logic               sda_in,
    output engine_state_t      nx,
    output logic               done
);

    // Drive line levels on entry to phase p
    function automatic engine_state_t enter_phase(input engine_state_t s,
                                                  input logic [PHASE_W-1:0] p);
        engine_state_t r;
        r = s;
        case (s.mode)
            MODE_START: begin
                if (p == 5'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (p == 5'd1) begin
                    r.sda = 1'b0;
                end else begin
                    r.scl = 1'b0;
                end
            end
            MODE_STOP: begin
                r.sda = 1'b0;
                r.scl = 1'b1;
            end
            MODE_WRITE: begin
                if (p <= PH_WR_LAST_BIT) begin
                    case (s.sub)
                        SUB_DATA: r.sda = s.shreg[BYTE_W-1];
                        SUB_HIGH: r.scl = 1'b1;
                        default: begin
                            r.scl   = 1'b0;
                            r.shreg = {s.shreg[BYTE_W-2:0], 1'b0};
                            if (p == PH_WR_LAST_BIT) begin
                                r.sda = 1'b1;
                            end
                        end
                    endcase
                end else if (p == PH_WR_ACK_REL) begin
                    r.sda = 1'b1;
                end else if (p == PH_WR_ACK_HIGH) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            default: begin
                if (p < PH_RD_ACK_DRV) begin
                    r.scl = ~p[0];
                end else if (p == PH_RD_ACK_DRV) begin
                    r.sda = (s.mode == MODE_RD_ACK) ? 1'b0 : 1'b1;
                end else if (p == PH_RD_ACK_HIGH) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    logic [DELAY_W-1:0] dly_eff;
    logic [DELAY_W:0]   div_inc;
    logic [PHASE_W-1:0] phase_inc;
    engine_state_t      s;

    assign dly_eff   = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign div_inc   = {1'b0, st.div} + (DELAY_W+1)'(1);
    assign phase_inc = st.phase + PHASE_W'(1);

    // Advance the running command, or take a new one when idle
    always_comb begin
        s    = st;
        done = 1'b0;
        if (st.busy) begin
            if (div_inc >= {1'b0, dly_eff}) begin
                // sample at the end of the phase
                if ((st.mode == MODE_WRITE) && (st.phase == PH_WR_ACK_HIGH)) begin
                    s.ack = sda_in;
                end else if (is_read(st.mode) && (st.phase < PH_RD_ACK_DRV)
                             && !st.phase[0]) begin
                    s.shreg = {st.shreg[BYTE_W-2:0], sda_in};
                end
                s.div = '0;
                s.sub = (st.sub == SUB_LOW) ? SUB_DATA : SUB_W'(st.sub + SUB_W'(1));
                if (phase_inc >= phase_count(st.mode)) begin
                    if ((st.mode == MODE_STOP) || is_read(st.mode)) begin
                        s.sda = 1'b1;
                    end
                    if (is_read(st.mode)) begin
                        s.rd_latch = s.shreg;
                    end
                    s.busy  = 1'b0;
                    s.phase = '0;
                    done    = 1'b1;
                end else begin
                    s.phase = phase_inc;
                    s       = enter_phase(s, phase_inc);
                end
            end else begin
                s.div = div_inc[DELAY_W-1:0];
            end
        end else if (cmd_valid && (mode <= MODE_RD_NACK)) begin
            s.mode  = mode;
            s.phase = '0;
            s.sub   = SUB_DATA;
            s.div   = '0;
            s.busy  = 1'b1;
            s.shreg = (mode == MODE_WRITE) ? wr_byte : '0;
            s       = enter_phase(s, '0);
        end
        nx = s;
    end

endmodule

// ===== src/i2c_master_byte_engine.sv =====
// I2C master byte engine: one tick request in, one line/status result out.
// The result of an accepted tick appears in the output register in the next cycle.
// Throughput: 1 tick per cycle while results are taken; the engine state register closes the state loop.
// A full output register with m_ready low holds s_ready low until the result is taken.
// Reset (aresetn low, synchronous): idle, lines released, delay_ticks = 10.
// Depends on i2cmbe_pkg, i2cmbe_step and i2c_master_byte_engine_macros.svh.
`include "i2c_master_byte_engine_macros.svh"
module i2c_master_byte_engine
    import i2cmbe_pkg::*;
#(
    parameter logic [DELAY_W-1:0] DELAY_TICKS_RESET = DELAY_RESET
)
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELAY_W-1:0] cfg_delay_ticks,
    // tick requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd_valid,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [BYTE_W-1:0]  s_wr_byte,
    input  logic               s_sda_in,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_scl,
    output logic               m_sda_out,
    output logic               m_busy_res,
    output logic               m_done_res,
    output logic [BYTE_W-1:0]  m_rd_byte,
    output logic               m_ack_bit
);

    engine_state_t      state_reg;
    engine_state_t      state_next;
    logic               done_next;
    logic [DELAY_W-1:0] delay_reg;
    logic               m_valid_reg;
    logic               done_reg;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    i2cmbe_step u_step (
        .st          (state_reg),
        .delay_ticks (delay_reg),
        .cmd_valid   (s_cmd_valid),
        .mode        (s_mode),
        .wr_byte     (s_wr_byte),
        .sda_in      (s_sda_in),
        .nx          (state_next),
        .done        (done_next)
    );

    // Hold the delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            delay_reg <= cfg_delay_ticks;
        end
    end

    // Advance engine state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_START, phase: '0, sub: SUB_DATA, div: '0,
                           shreg: '0, busy: 1'b0, scl: 1'b1, sda: 1'b1,
                           ack: 1'b1, rd_latch: '0};
            done_reg  <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_scl      = state_reg.scl;
    assign m_sda_out  = state_reg.sda;
    assign m_busy_res = state_reg.busy;
    assign m_done_res = done_reg;
    assign m_rd_byte  = state_reg.rd_latch;
    assign m_ack_bit  = state_reg.ack;

    `I2CMBE_ASSERT_IMP(a_done_not_busy, done_reg, !state_reg.busy)
    `I2CMBE_ASSERT_IMP(a_idle_clean, !state_reg.busy,
                       (state_reg.phase == '0) && (state_reg.div == '0))
    `I2CMBE_ASSERT(a_phase_range,
                   !state_reg.busy || (state_reg.phase < phase_count(state_reg.mode)))

endmodule
